FILE: hw/rtl/mtf_pkg.sv
// Shared types for the move-to-front codec: the request wave and broadcast control.
package mtf_pkg;

  typedef struct packed {
    logic       valid;
    logic       done;
    logic [7:0] carry;
    logic [7:0] res;
  } wave_t;

  typedef struct packed {
    logic       mode;
    logic       clr;
    logic       wr_front;
    logic [7:0] val;
    logic [7:0] pos;
    logic [7:0] front;
  } ctl_t;

endpackage

FILE: hw/rtl/move_to_front_codec.sv
// Move-to-front codec top level: control block and a chain of list cells.
// An accepted request launches a wave through every list cell before its result is registered.
// A new request is accepted only after the previous wave has crossed the chain and written the front entry.
// A result may wait on the output while the next request is already in the chain.
// Reset (asynchronous, active low) restores the identity list and selects encoding.
module move_to_front_codec #(
  parameter int ALPHABET = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_in_i,
  input  logic       start_of_block_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_decode_mode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o
);
  import mtf_pkg::*;

  ctl_t  ctl;
  wave_t wave [ALPHABET+1];

  mtf_ctrl #(
    .ALPHABET(ALPHABET)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_in_i        (data_in_i),
    .start_of_block_i (start_of_block_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_decode_mode_i(cfg_decode_mode_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_out_o       (data_out_o),
    .ctl_o            (ctl),
    .wave_o           (wave[0]),
    .fin_i            (wave[ALPHABET])
  );

  for (genvar k = 0; k < ALPHABET; k++) begin : g_cell
    mtf_cell #(
      .K       (k),
      .ALPHABET(ALPHABET)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .wave_i(wave[k]),
      .wave_o(wave[k+1])
    );
  end

endmodule

FILE: hw/rtl/mtf_cell.sv
// One list entry of the move-to-front chain with its stage of the request wave.
module mtf_cell #(
  parameter int K        = 0,
  parameter int ALPHABET = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mtf_pkg::ctl_t  ctl_i,
  input  mtf_pkg::wave_t wave_i,
  output mtf_pkg::wave_t wave_o
);
  import mtf_pkg::*;

  localparam logic [7:0] KB       = 8'(K);
  localparam bit         IS_FIRST = (K == 0);
  localparam bit         IS_LAST  = (K == ALPHABET - 1);
  localparam bit         KLOW     = (K < 256);

  logic [7:0] sym_q, sym_d;
  wave_t      wave_q, wave_d;
  logic       hit;

  always_comb begin
    if (ctl_i.mode) begin
      hit = KLOW && (KB == ctl_i.pos);
    end else begin
      hit = (sym_q == ctl_i.val) || IS_LAST;
    end
  end

  always_comb begin
    sym_d  = sym_q;
    wave_d = '0;
    if (wave_i.valid) begin
      wave_d = wave_i;
      if (!wave_i.done) begin
        if (hit) begin
          wave_d.done = 1'b1;
          wave_d.res  = ctl_i.mode ? sym_q : KB;
        end else begin
          wave_d.carry = sym_q;
        end
        if (!IS_FIRST) begin
          sym_d = wave_i.carry;
        end
      end
    end
    if (IS_FIRST && ctl_i.wr_front) begin
      sym_d = ctl_i.front;
    end
    if (ctl_i.clr) begin
      sym_d = KB;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q  <= KB;
      wave_q <= '0;
    end else begin
      sym_q  <= sym_d;
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule

FILE: hw/rtl/mtf_ctrl.sv
// Request intake, mode register, wave launch and result buffering for the codec.
module mtf_ctrl #(
  parameter int ALPHABET = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     data_in_i,
  input  logic           start_of_block_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_decode_mode_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     data_out_o,
  output mtf_pkg::ctl_t  ctl_o,
  output mtf_pkg::wave_t wave_o,
  input  mtf_pkg::wave_t fin_i
);
  import mtf_pkg::*;

  localparam logic [8:0] LIM  = (ALPHABET > 255) ? 9'd256 : 9'(ALPHABET);
  localparam logic [7:0] LAST = 8'(LIM - 9'd1);

  logic       mode_q;
  logic       busy_q, busy_d;
  logic       start_q;
  logic [7:0] val_q;
  logic       pend_v_q, pend_v_d;
  logic [7:0] pend_q, pend_d;
  logic       out_v_q, out_v_d;
  logic [7:0] out_q, out_d;
  logic       acc, fin, out_free, sat;

  assign in_stall_o  = busy_q | pend_v_q;
  assign acc         = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = ~busy_q;
  assign fin         = fin_i.valid;
  assign out_free    = ~out_v_q | ~out_stall_i;
  assign sat         = ({1'b0, val_q} >= LIM);

  always_comb begin
    ctl_o          = '0;
    ctl_o.mode     = mode_q;
    ctl_o.clr      = acc & start_of_block_i;
    ctl_o.wr_front = fin;
    ctl_o.val      = val_q;
    ctl_o.pos      = sat ? LAST : val_q;
    ctl_o.front    = mode_q ? fin_i.res : val_q;
  end

  always_comb begin
    wave_o       = '0;
    wave_o.valid = start_q;
    wave_o.carry = val_q;
  end

  always_comb begin
    busy_d   = busy_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q;
    out_d    = out_q;
    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
    if (pend_v_q && out_free) begin
      out_v_d  = 1'b1;
      out_d    = pend_q;
      pend_v_d = 1'b0;
    end else if (fin && out_free) begin
      out_v_d = 1'b1;
      out_d   = fin_i.res;
    end else if (fin) begin
      pend_v_d = 1'b1;
      pend_d   = fin_i.res;
    end
    if (acc) begin
      busy_d = 1'b1;
    end else if (fin) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      busy_q   <= 1'b0;
      start_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_decode_mode_i;
      end
      busy_q   <= busy_d;
      start_q  <= acc;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      val_q <= data_in_i;
    end
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign data_out_o  = out_q;

  a_fin_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> busy_q && !pend_v_q)
    else $error("wave finished with no request in flight or buffer full");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> busy_q)
    else $error("wave launched while idle");

  a_pend_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> out_v_q)
    else $error("pending result with empty output register");

  a_acc_launch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> busy_q && start_q)
    else $error("accepted request did not launch a wave");

endmodule

FILE: tb/move_to_front_codec_tb.sv
// Self-checking testbench for the move-to-front codec: directed and random blocks in both modes.
module move_to_front_codec_tb;

  localparam int ALPHABET     = 256;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 450;
  localparam int SEGMENTS     = 8;
  localparam bit MODE_ENCODE  = 1'b0;
  localparam bit MODE_DECODE  = 1'b1;

  logic       clk_i             = 1'b0;
  logic       rst_ni            = 1'b0;
  logic       in_valid_i        = 1'b0;
  logic [7:0] data_in_i         = '0;
  logic       start_of_block_i  = 1'b0;
  logic       cfg_valid_i       = 1'b0;
  logic       cfg_decode_mode_i = 1'b0;
  logic       out_stall_i       = 1'b0;
  logic       in_stall_o;
  logic       cfg_ready_o;
  logic       out_valid_o;
  logic [7:0] data_out_o;

  logic [7:0]  symbol_order [ALPHABET];
  bit          decode_sel;
  logic [7:0]  pending_codes [$];
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned stall_hold;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  move_to_front_codec #(
    .ALPHABET(ALPHABET)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_in_i        (data_in_i),
    .start_of_block_i (start_of_block_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_decode_mode_i(cfg_decode_mode_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_out_o       (data_out_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void restore_order();
    for (int k = 0; k < ALPHABET; k++) symbol_order[k] = k[7:0];
  endfunction

  function automatic logic [7:0] mtf_code(input logic [7:0] val, input logic sob);
    int         pos;
    logic [7:0] sym;
    if (sob) restore_order();
    if (decode_sel) begin
      pos = int'(val);
      if (pos >= ALPHABET) pos = ALPHABET - 1;
      sym = symbol_order[pos];
    end else begin
      pos = ALPHABET - 1;
      sym = val;
      for (int j = ALPHABET - 1; j >= 0; j--) begin
        if (symbol_order[j] == val) pos = j;
      end
    end
    for (int k = pos; k > 0; k--) symbol_order[k] = symbol_order[k - 1];
    symbol_order[0] = sym;
    return decode_sel ? sym : pos[7:0];
  endfunction

  task automatic write_mode(input bit mode);
    cfg_decode_mode_i <= mode;
    cfg_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    decode_sel = mode;
  endtask

  task automatic send_symbol(input logic [7:0] val, input logic sob);
    in_valid_i       <= 1'b1;
    data_in_i        <= val;
    start_of_block_i <= sob;
    do @(posedge clk_i); while (in_stall_o);
    pending_codes.push_back(mtf_code(val, sob));
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(ALPHABET + 2, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_encode_extremes();
    idle_pct  = 0;
    stall_pct = 0;
    write_mode(MODE_ENCODE);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0,   1'b1);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0,   1'b0);
    send_symbol(8'd1,   1'b0);
    send_symbol(8'd128, 1'b0);
    send_symbol(8'd128, 1'b0);
    send_symbol(8'd85,  1'b0);
    send_symbol(8'd170, 1'b0);
    send_symbol(8'd255, 1'b1);
    send_symbol(8'd254, 1'b0);
    drain_results();
  endtask

  task automatic test_decode_extremes();
    write_mode(MODE_DECODE);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0,   1'b1);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0,   1'b0);
    send_symbol(8'd1,   1'b0);
    send_symbol(8'd2,   1'b0);
    send_symbol(8'd128, 1'b0);
    send_symbol(8'd254, 1'b1);
    send_symbol(8'd85,  1'b0);
    send_symbol(8'd170, 1'b0);
    send_symbol(8'd0,   1'b0);
    drain_results();
  endtask

  task automatic test_random_blocks();
    int unsigned sent;
    int unsigned block_len;
    logic [7:0]  val;
    logic        sob;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      write_mode(seg[0] ? MODE_DECODE : MODE_ENCODE);
      sent = 0;
      while (sent < RANDOM_ITEMS / SEGMENTS) begin
        block_len = $urandom_range(40, 1);
        for (int n = 0; n < block_len && sent < RANDOM_ITEMS / SEGMENTS; n++) begin
          sob = (n == 0);
          if ($urandom_range(19) == 0) sob = 1'($urandom_range(1));
          if ($urandom_range(1) == 0)
            val = decode_sel ? 8'($urandom_range(7)) : 8'($urandom_range(15));
          else
            val = 8'($urandom_range(255));
          send_symbol(val, sob);
          sent++;
        end
      end
      drain_results();
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_hold  <= ($urandom_range(9) == 0) ? $urandom_range(ALPHABET + 8) : 0;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_result
    logic [7:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_codes.size() == 0) begin
        $error("data_out: expected nothing, actual %0d", data_out_o);
        mismatch_count++;
      end else begin
        want = pending_codes.pop_front();
        if (data_out_o !== want) begin
          $error("data_out: expected %0d, actual %0d", want, data_out_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("move_to_front_codec_tb: FAIL");
      $finish;
    end
  end

  initial begin
    restore_order();
    decode_sel     = MODE_ENCODE;
    idle_pct       = 0;
    stall_pct      = 0;
    stall_hold     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encode_extremes();
    test_decode_extremes();
    test_random_blocks();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (ALPHABET + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_codes.size() == 0) begin
      $display("move_to_front_codec_tb: PASS");
    end else begin
      $display("move_to_front_codec_tb: FAIL");
    end
    $finish;
  end

endmodule
